// ===== hdl/vad_pkg.sv =====
package vad_pkg;

  // Datapath widths. Magnitudes are normalized so the larger one lands in
  // [2^40, 2^41); CORDIC gain and sign bit fit in 44 bits.
  localparam int XY_W         = 44;
  localparam int NORM_TOP     = 40;
  localparam int NORM_STAGES  = 6;   // shifts of 32, 16, 8, 4, 2, 1
  localparam int Z_W          = 25;  // angle accumulator, 2^-16 degree units
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 23;
  localparam int ANGLE_W      = 9;
  localparam int K_W          = 7;   // rounded first-quadrant degrees, 0..90

  localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] DEG_360 = ANGLE_W'(360);
  localparam logic signed [Z_W-1:0] Z_MAX = Z_W'(90 << FRAC_BITS);
  localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(1 << (FRAC_BITS - 1));

  // atan(2^-i) in degrees, units of 2^-16 degree
  localparam logic signed [Z_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
    Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945),
    Z_W'(234379),  Z_W'(117304),  Z_W'(58666),  Z_W'(29335),
    Z_W'(14668),   Z_W'(7334),    Z_W'(3667),   Z_W'(1833),
    Z_W'(917),     Z_W'(458),     Z_W'(229),    Z_W'(115),
    Z_W'(57),      Z_W'(29),      Z_W'(14),     Z_W'(7),
    Z_W'(4),       Z_W'(2),       Z_W'(1)
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   dx_neg;
    logic                   dy_neg;
    logic                   zero;
  } stage_t;

endpackage

// ===== hdl/vector_angle_degrees.sv =====
// Pipeline: 1 difference stage, 6 normalize stages, 23 CORDIC stages,
//   1 round/quadrant stage. Throughput: one item per cycle unless
//   out_ready stalls; every stage is a register with its own valid, so
//   bubbles collapse and input is taken while a result waits.
// Reset: synchronous, active high; clears all stage valids, not data.
module vector_angle_degrees import vad_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] from_x,
  input  logic [COORD_BITS-1:0] from_y,
  input  logic [COORD_BITS-1:0] to_x,
  input  logic [COORD_BITS-1:0] to_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ANGLE_W-1:0]    angle_degrees
);

  // Chain layout: node 0 is the difference stage output, nodes 1..6 the
  // normalizer outputs, nodes 7..29 the CORDIC cell outputs. The final
  // node feeds the rounding / quadrant stage that holds the result.
  localparam int NODES = 1 + NORM_STAGES + CORDIC_STEPS;

  stage_t chain_data  [NODES];
  logic   chain_valid [NODES];
  logic   chain_ready [NODES];

  // Difference vector and magnitudes. Inputs are sign-extended one bit so
  // the difference is exact; magnitudes are zero-extended into the chain.
  vad_delta #(
    .COORD_BITS (COORD_BITS)
  ) u_delta (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .from_x    (from_x),
    .from_y    (from_y),
    .to_x      (to_x),
    .to_y      (to_y),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  // Binary normalizer: each cell shifts both magnitudes by a fixed power
  // of two when the larger stays below 2^41, so the larger one ends up in
  // [2^40, 2^41). A zero vector passes through unchanged.
  for (genvar n = 0; n < NORM_STAGES; n++) begin : g_norm
    vad_norm_cell #(
      .SHIFT (1 << (NORM_STAGES - 1 - n))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[n]),
      .in_ready  (chain_ready[n]),
      .in_data   (chain_data[n]),
      .out_valid (chain_valid[n+1]),
      .out_ready (chain_ready[n+1]),
      .out_data  (chain_data[n+1])
    );
  end

  // CORDIC vectoring: one rotation per cell, step i uses shift i and
  // atan(2^-i). z accumulates the first-quadrant angle in 2^-16 degree.
  for (genvar c = 0; c < CORDIC_STEPS; c++) begin : g_cordic
    vad_cordic_cell #(
      .STEP (c)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[NORM_STAGES+c]),
      .in_ready  (chain_ready[NORM_STAGES+c]),
      .in_data   (chain_data[NORM_STAGES+c]),
      .out_valid (chain_valid[NORM_STAGES+c+1]),
      .out_ready (chain_ready[NORM_STAGES+c+1]),
      .out_data  (chain_data[NORM_STAGES+c+1])
    );
  end

  // Clamp z to 0..90 degrees, round halves up, then map the quadrant from
  // the difference signs. A zero vector reports 0; the positive x axis
  // approached from below wraps 360 to 0.
  vad_quadrant u_quadrant (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[NODES-1]),
    .in_ready  (chain_ready[NODES-1]),
    .in_data   (chain_data[NODES-1]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle     (angle_degrees)
  );

  // Checks

  logic fin_fire;
  assign fin_fire = chain_valid[NODES-1] && chain_ready[NODES-1];

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_degrees < DEG_360))
    else $error("angle out of range");

  a_zero_vector: assert property (@(posedge clk) disable iff (rst)
    (fin_fire && chain_data[NODES-1].zero) |=> (angle_degrees == '0))
    else $error("zero vector did not give 0");

  a_head_free: assert property (@(posedge clk) disable iff (rst)
    !chain_valid[0] |-> in_ready)
    else $error("input stalled with empty head stage");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ===== hdl/vad_delta.sv =====
module vad_delta import vad_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] from_x,
  input  logic [COORD_BITS-1:0] from_y,
  input  logic [COORD_BITS-1:0] to_x,
  input  logic [COORD_BITS-1:0] to_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output stage_t                out_data
);

  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0] mag_x, mag_y;
  stage_t data_next;

  always_comb begin
    dx = $signed({to_x[COORD_BITS-1], to_x}) - $signed({from_x[COORD_BITS-1], from_x});
    dy = $signed({to_y[COORD_BITS-1], to_y}) - $signed({from_y[COORD_BITS-1], from_y});
    mag_x = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    mag_y = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
    data_next.x      = $signed(XY_W'(mag_x));
    data_next.y      = $signed(XY_W'(mag_y));
    data_next.z      = '0;
    data_next.dx_neg = dx[COORD_BITS];
    data_next.dy_neg = dy[COORD_BITS];
    data_next.zero   = (dx == '0) && (dy == '0);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hdl/vad_norm_cell.sv =====
module vad_norm_cell import vad_pkg::*; #(
  parameter int SHIFT = 1
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  stage_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output stage_t out_data
);

  // shift both when the larger magnitude stays below 2^41 after the shift
  localparam int LOW = NORM_TOP + 1 - SHIFT;

  logic   fits;
  stage_t data_next;

  always_comb begin
    fits = (in_data.x[XY_W-1:LOW] == '0) && (in_data.y[XY_W-1:LOW] == '0);
    data_next = in_data;
    if (fits) begin
      data_next.x = in_data.x <<< SHIFT;
      data_next.y = in_data.y <<< SHIFT;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hdl/vad_cordic_cell.sv =====
module vad_cordic_cell import vad_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  stage_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output stage_t out_data
);

  logic signed [XY_W-1:0] xs, ys;
  stage_t data_next;

  // one vectoring rotation; arithmetic shifts floor
  always_comb begin
    xs = in_data.x >>> STEP;
    ys = in_data.y >>> STEP;
    data_next = in_data;
    if (!in_data.y[XY_W-1]) begin
      data_next.x = in_data.x + ys;
      data_next.y = in_data.y - xs;
      data_next.z = in_data.z + ATAN_TABLE[STEP];
    end else begin
      data_next.x = in_data.x - ys;
      data_next.y = in_data.y + xs;
      data_next.z = in_data.z - ATAN_TABLE[STEP];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hdl/vad_quadrant.sv =====
module vad_quadrant import vad_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  stage_t             in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ANGLE_W-1:0] angle
);

  logic signed [Z_W-1:0] z_clamp, z_round;
  logic [K_W-1:0]        k;
  logic [ANGLE_W-1:0]    k_ext, angle_next;

  always_comb begin
    if (in_data.z[Z_W-1]) begin
      z_clamp = '0;
    end else if (in_data.z > Z_MAX) begin
      z_clamp = Z_MAX;
    end else begin
      z_clamp = in_data.z;
    end
    z_round = z_clamp + Z_HALF;
    k       = z_round[FRAC_BITS +: K_W];
    k_ext   = ANGLE_W'(k);
    unique case ({in_data.dx_neg, in_data.dy_neg})
      2'b00: angle_next = k_ext;
      2'b10: angle_next = DEG_180 - k_ext;
      2'b11: angle_next = DEG_180 + k_ext;
      2'b01: angle_next = (k == '0) ? '0 : DEG_360 - k_ext;
      default: angle_next = '0;
    endcase
    if (in_data.zero) begin
      angle_next = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      angle <= angle_next;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vad_pkg::ANGLE_W;

  localparam int COORD = 16;
  localparam int N_RANDOM = 1800;
  localparam int STALL_LIMIT = 2000;   // cycles with no handshake on either side
  localparam int HOLDOFF_AT = 600;     // result count that starts the long stall
  localparam int HOLDOFF_LEN = 300;
  localparam int DRAIN_CYCLES = 40;    // pipeline is 31 deep
  localparam int PREDICT = -1;         // row has no typed-in expectation

  // CORDIC constants: atan(2^-i) in 2^-16 degree units
  localparam int ANGLE_STEPS = 23;
  localparam int Q = 16;
  localparam int NORM_AT = 40;
  localparam longint ATAN_Q16 [ANGLE_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1
  };

  typedef struct {
    int fx;
    int fy;
    int tx;
    int ty;
    int want;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD-1:0] from_x = '0;
  logic [COORD-1:0] from_y = '0;
  logic [COORD-1:0] to_x = '0;
  logic [COORD-1:0] to_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ANGLE_W-1:0] angle_degrees;

  logic [ANGLE_W-1:0] expected_angles[$];
  point_row_t directed_rows[$];
  int mismatches = 0;
  int send_calm = 0;
  int recv_calm = 0;
  logic [ANGLE_W-1:0] oldest_angle;

  vector_angle_degrees #(.COORD_BITS(COORD)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .from_x(from_x),
    .from_y(from_y),
    .to_x(to_x),
    .to_y(to_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .angle_degrees(angle_degrees)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Bit-exact angle: magnitudes normalized to >= 2^40, 23 vectoring steps,
  // clamp to the first quadrant, round half up, then fold back by signs.
  function automatic logic [ANGLE_W-1:0] predict_angle(
      input logic [COORD-1:0] fx, fy, tx, ty);
    longint dx, dy, a, b, m, x, y, z, xs, ys;
    longint k, ang;
    dx = longint'($signed(tx)) - longint'($signed(fx));
    dy = longint'($signed(ty)) - longint'($signed(fy));
    a = (dx < 0) ? -dx : dx;
    b = (dy < 0) ? -dy : dy;
    if (a == 0 && b == 0) return '0;
    m = (a > b) ? a : b;
    while (m < (64'sd1 <<< NORM_AT)) begin
      m = m <<< 1;
      a = a <<< 1;
      b = b <<< 1;
    end
    x = a;
    y = b;
    z = 0;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q16[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (64'sd90 <<< Q)) z = 64'sd90 <<< Q;
    k = (z + (64'sd1 <<< (Q - 1))) >>> Q;
    if (dx >= 0 && dy >= 0) ang = k;
    else if (dx < 0 && dy >= 0) ang = 180 - k;
    else if (dx < 0) ang = 180 + k;
    else ang = (360 - k) % 360;
    return ANGLE_W'(ang % 360);
  endfunction

  // Mostly zero or short gaps, a few long ones, and calm runs with none.
  function automatic int idle_cycles(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic point_row_t mk_row(input int fx, fy, tx, ty, want);
    point_row_t r;
    r.fx = fx;
    r.fy = fy;
    r.tx = tx;
    r.ty = ty;
    r.want = want;
    return r;
  endfunction

  task automatic add_row(input int fx, fy, tx, ty, want);
    directed_rows.insert(directed_rows.size(), mk_row(fx, fy, tx, ty, want));
  endtask

  task automatic queue_angle(input logic [ANGLE_W-1:0] angle);
    expected_angles.insert(expected_angles.size(), angle);
  endtask

  task automatic send_item(input logic [COORD-1:0] fx, fy, tx, ty, input int want);
    int gap;
    gap = idle_cycles(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    from_x <= fx;
    from_y <= fy;
    to_x <= tx;
    to_y <= ty;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (want == PREDICT) queue_angle(predict_angle(fx, fy, tx, ty));
    else queue_angle(ANGLE_W'(want));
  endtask

  // Random point pair; most are offsets from a random origin so that small,
  // near-axis and mid-size vectors all get regular coverage.
  task automatic random_pair(output logic [COORD-1:0] fx, fy, tx, ty);
    int kind;
    int span;
    logic [COORD-1:0] corner [5];
    corner = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    kind = $urandom_range(0, 99);
    fx = COORD'($urandom);
    fy = COORD'($urandom);
    if (kind < 30) begin
      tx = COORD'($urandom);
      ty = COORD'($urandom);
    end else if (kind < 90) begin
      span = (kind < 60) ? 20 : (kind < 75) ? 2000 : 1;
      tx = fx + COORD'($urandom_range(0, 2 * span) - span);
      ty = fy + COORD'($urandom_range(0, 2 * span) - span);
      // near-axis: blow up one component
      if (kind >= 75) begin
        if ($urandom_range(0, 1)) tx = COORD'($urandom);
        else ty = COORD'($urandom);
      end
    end else begin
      fx = corner[$urandom_range(0, 4)];
      fy = corner[$urandom_range(0, 4)];
      tx = corner[$urandom_range(0, 4)];
      ty = corner[$urandom_range(0, 4)];
    end
  endtask

  // Result checker: oldest expectation against each accepted result.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_angles.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing pending", angle_degrees));
      end else begin
        oldest_angle = expected_angles.pop_front();
        if (angle_degrees !== oldest_angle)
          report_mismatch($sformatf("angle_degrees %0d, want %0d",
                                    angle_degrees, oldest_angle));
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off that lets the
  // pipeline fill and push back on the sender.
  initial begin
    int gap;
    int got;
    bit held;
    got = 0;
    held = 1'b0;
    forever begin
      gap = idle_cycles(recv_calm);
      if (!held && got >= HOLDOFF_AT) begin
        held = 1'b1;
        gap = HOLDOFF_LEN;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      got++;
    end
  end

  // Watchdog: ends the run if neither side moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [COORD-1:0] fx, fy, tx, ty;

    // Axes and the zero vector
    add_row(0, 0, 0, 0, 0);
    add_row(1234, -555, 1234, -555, 0);
    add_row(0, 0, 100, 0, 0);
    add_row(0, 0, 0, 100, 90);
    add_row(0, 0, -100, 0, 180);
    add_row(0, 0, 0, -100, 270);
    // Full-scale differences along each axis
    add_row(-32768, 7, 32767, 7, 0);
    add_row(32767, -9, -32768, -9, 180);
    add_row(3, -32768, 3, 32767, 90);
    add_row(3, 32767, 3, -32768, 270);
    // Diagonals, unit and full scale
    add_row(0, 0, 1, 1, 45);
    add_row(0, 0, -1, 1, 135);
    add_row(0, 0, -1, -1, 225);
    add_row(0, 0, 1, -1, 315);
    add_row(-32768, -32768, 32767, 32767, 45);
    add_row(32767, 32767, -32768, -32768, 225);
    // Just below the positive x axis wraps to 0; near half-degree steps
    add_row(-32768, 32767, 32767, 32766, PREDICT);
    add_row(0, 0, 32767, 286, PREDICT);
    add_row(0, 0, 32767, 285, PREDICT);
    add_row(0, 0, -32768, 287, PREDICT);
    add_row(0, 0, 3, 4, PREDICT);
    add_row(0, 0, -7, 2, PREDICT);
    add_row(0, 0, 1, -32768, PREDICT);
    add_row(0, 0, -32768, 1, PREDICT);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(COORD'(directed_rows[i].fx), COORD'(directed_rows[i].fy),
                COORD'(directed_rows[i].tx), COORD'(directed_rows[i].ty),
                directed_rows[i].want);

    for (int n = 0; n < N_RANDOM; n++) begin
      random_pair(fx, fy, tx, ty);
      send_item(fx, fy, tx, ty, PREDICT);
    end
    in_valid <= 1'b0;

    while (expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
